@@ sv/tmm_pkg.sv @@
// Shared types, constants and arithmetic helpers of the triangular matrix multiply core.
package tmm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_LIM   = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int FRAC_BITS = 32;
    localparam int WORD_W    = 64;
    localparam int ACC_W     = 2 * WORD_W;
    localparam int HALF_W    = WORD_W / 2;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int MUL_CELLS = 4;

    localparam logic [WORD_W-1:0] ONE_Q    = WORD_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] SIGN_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SIGN_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]  RND_POS  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]  RND_NEG  = RND_POS + ACC_W'(1);

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_SIDE  = 3'd0,
        CFG_UPPER = 3'd1,
        CFG_TRANS = 3'd2,
        CFG_UNIT  = 3'd3,
        CFG_ROWS  = 3'd4,
        CFG_COLS  = 3'd5,
        CFG_ALPHA = 3'd6
    } cfg_index_t;

    typedef enum logic [5:0] {
        S_IDLE, S_MWAIT, S_CLR, S_ERD, S_ELD, S_EWT,
        S_L1_RD, S_L1_CK, S_L1_T, S_L1_IRD, S_L1_IM, S_L1_IA,
        S_L1_DG, S_L1_DM, S_L1_DT, S_L1_WR, S_L1_ADV,
        S_L2_RD, S_L2_T0, S_L2_DM, S_L2_DT, S_L2_KS, S_L2_KRD,
        S_L2_KM, S_L2_KA, S_L2_FIN, S_L2_WR,
        S_R_OS, S_R_PS, S_R_PE, S_R_OA,
        S_AX, S_AX_CK, S_AX_F, S_AX_RD1, S_AX_M, S_AX_RD2, S_AX_A, S_AX_NX,
        S_SC, S_SC_M, S_SC_T, S_SC_CK, S_SC_RD, S_SC_M2, S_SC_W
    } state_t;

    // One stage of the multiplier chain: sign, magnitudes and running sum.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] my;
        logic [ACC_W-1:0]  acc;
    } mul_stage_t;

    // Saturating add: returns {overflow, sum}.
    function automatic logic [WORD_W:0] qadd(input logic [WORD_W-1:0] x,
                                              input logic [WORD_W-1:0] y);
        logic [WORD_W-1:0] r;
        logic              ovf;
        r   = x + y;
        ovf = (x[WORD_W-1] == y[WORD_W-1]) && (r[WORD_W-1] != x[WORD_W-1]);
        if (ovf)
        begin
            r = x[WORD_W-1] ? SIGN_MIN : SIGN_MAX;
        end
        return {ovf, r};
    endfunction

endpackage

@@ sv/tmm_mul_cell.sv @@
// One cell of the multiplier chain: adds one 32x32 partial product and passes on.
module tmm_mul_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          part_sel,
    input  tmm_pkg::mul_stage_t stage_in,
    output tmm_pkg::mul_stage_t stage_out
);
    import tmm_pkg::*;

    logic [HALF_W-1:0] xh;
    logic [HALF_W-1:0] yh;
    logic [WORD_W-1:0] prod;
    logic [ACC_W-1:0]  shifted;
    mul_stage_t        stage_reg;
    mul_stage_t        stage_next;

    always_comb
    begin
        xh   = part_sel[0] ? stage_in.mx[WORD_W-1:HALF_W] : stage_in.mx[HALF_W-1:0];
        yh   = part_sel[1] ? stage_in.my[WORD_W-1:HALF_W] : stage_in.my[HALF_W-1:0];
        prod = WORD_W'(xh) * WORD_W'(yh);
        case (part_sel)
            2'd0:    shifted = {{WORD_W{1'b0}}, prod};
            2'd3:    shifted = {prod, {WORD_W{1'b0}}};
            default: shifted = {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};
        endcase
        stage_next     = stage_in;
        stage_next.acc = stage_in.acc + shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

@@ sv/tmm_qmul.sv @@
// Fixed-point multiplier: sign split, chain of partial-product cells, rounding, saturation.
module tmm_qmul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [tmm_pkg::WORD_W-1:0] x,
    input  logic [tmm_pkg::WORD_W-1:0] y,
    output logic                       done,
    output logic [tmm_pkg::WORD_W-1:0] res,
    output logic                       sat
);
    import tmm_pkg::*;

    mul_stage_t        chain [MUL_CELLS+1];
    mul_stage_t        head_reg;
    logic              r1_valid_reg;
    logic [ACC_W-1:0]  r1_val_reg;
    logic [ACC_W-1:0]  r1_val_next;
    logic              done_reg;
    logic [WORD_W-1:0] res_reg;
    logic              sat_reg;
    logic [ACC_W-1:WORD_W+FRAC_BITS-1] hi_bits;
    logic              fits;

    // head: magnitudes and product sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg.valid <= go;
            head_reg.neg   <= x[WORD_W-1] ^ y[WORD_W-1];
            head_reg.mx    <= x[WORD_W-1] ? (WORD_W'(0) - x) : x;
            head_reg.my    <= y[WORD_W-1] ? (WORD_W'(0) - y) : y;
            head_reg.acc   <= '0;
        end
    end

    assign chain[0] = head_reg;

    for (genvar g = 0; g < MUL_CELLS; g++)
    begin : g_cell
        tmm_mul_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .part_sel  (2'(g)),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    // two's complement of the product folded into the rounding add
    assign r1_val_next = chain[MUL_CELLS].neg ? (~chain[MUL_CELLS].acc + RND_NEG)
                                              : (chain[MUL_CELLS].acc + RND_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
        end
        else
        begin
            r1_valid_reg <= chain[MUL_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[MUL_CELLS].valid)
        begin
            r1_val_reg <= r1_val_next;
        end
    end

    assign hi_bits = r1_val_reg[ACC_W-1:WORD_W+FRAC_BITS-1];
    assign fits    = (&hi_bits) || !(|hi_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= r1_valid_reg;
            if (r1_valid_reg)
            begin
                sat_reg <= !fits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1_valid_reg)
        begin
            if (fits)
            begin
                res_reg <= r1_val_reg[WORD_W+FRAC_BITS-1:FRAC_BITS];
            end
            else
            begin
                res_reg <= r1_val_reg[ACC_W-1] ? SIGN_MIN : SIGN_MAX;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;

endmodule

@@ sv/triangular_matrix_multiply_core.sv @@
// Top level of the triangular matrix multiply core: stores, sequencer and result port.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready. s_tuser carries the action:
//   load an A element, load a B element, or run. Loads write one Q32.32
//   word into the A or B store at (row, col). A run overwrites B with
//   alpha*op(A)*B or alpha*B*op(A) following the classic loop order of
//   the selected case, then emits B column by column on m_tvalid/m_tready,
//   m_tlast on the final element, m_tuser holding the saturation flag of
//   the run.
//   Each multiply goes through the multiplier's stages (sign split, four
//   partial-product cells, round, saturate). Emission of each result item
//   steps through a store read, a load of the result register and a wait
//   for m_tready.
//   The block takes one item at a time: s_tready is high only when no run
//   is in flight. A stall on m_tready holds the current result item and
//   pauses the emission; nothing is dropped.
//   Reset clears control state and loads the register defaults (left side,
//   lower, no transpose, non-unit, 8x8, alpha 1.0). Store contents are
//   undefined until written. Configuration is written on cfg_we.
module triangular_matrix_multiply_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[69:6]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[69:6]
    output logic        m_tlast,
    output logic        m_tuser    // saturated[0]
);
    import tmm_pkg::*;

    // configuration
    logic              side_reg, upper_reg, trans_reg, unit_reg;
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [WORD_W-1:0] alpha_reg;

    // stores
    logic [WORD_W-1:0] a_mem [DEPTH];
    logic [WORD_W-1:0] b_mem [DEPTH];
    logic [WORD_W-1:0] a_rd, b_rd;
    logic [ADDR_W-1:0] a_raddr, b_raddr, a_waddr, b_waddr;
    logic              a_we, b_we;
    logic [WORD_W-1:0] a_wdata, b_wdata;

    // sequencer
    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    state_t            sc_ret_reg, sc_ret_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [WORD_W-1:0] t_reg, t_next, bh_reg, bh_next;
    logic [DIM_W-1:0]  m_reg, m_next, n_reg, n_next;
    logic              sat_reg, sat_next;
    logic [DIM_W-1:0]  m_clamp, n_clamp;
    logic [IDX_W-1:0]  mlast, nlast;
    logic              nounit, r_asc;
    logic [IDX_W-1:0]  ax_dst, ax_src;

    // result register
    logic              ov_reg, ov_next;
    logic [IDX_W-1:0]  orow_reg, orow_next, ocol_reg, ocol_next;
    logic [WORD_W-1:0] oval_reg, oval_next;
    logic              olast_reg, olast_next, osat_reg, osat_next;

    // multiplier and adder
    logic              mul_go, mul_done, mul_sat;
    logic [WORD_W-1:0] mul_x, mul_y, mul_res;
    logic [WORD_W-1:0] add_a;
    logic [WORD_W:0]   add_out;

    logic              in_acc;
    action_t           in_act;
    logic [IDX_W-1:0]  in_row, in_col;
    logic [WORD_W-1:0] in_val;

    assign in_acc = s_tvalid && s_tready;
    assign in_act = action_t'(s_tuser);
    assign in_row = s_tdata[2:0];
    assign in_col = s_tdata[5:3];
    assign in_val = s_tdata[69:6];

    assign m_clamp = (rows_reg > DIM_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : rows_reg;
    assign n_clamp = (cols_reg > DIM_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : cols_reg;
    assign mlast   = IDX_W'(m_reg - DIM_W'(1));
    assign nlast   = IDX_W'(n_reg - DIM_W'(1));
    assign nounit  = !unit_reg;
    assign r_asc   = !(trans_reg ^ upper_reg);
    // axpy columns: without transpose the outer column receives, else the inner one
    assign ax_dst  = trans_reg ? k_reg : j_reg;
    assign ax_src  = trans_reg ? j_reg : k_reg;

    tmm_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res),
        .sat   (mul_sat)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 1'b0;
            upper_reg <= 1'b0;
            trans_reg <= 1'b0;
            unit_reg  <= 1'b0;
            rows_reg  <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
            alpha_reg <= ONE_Q;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SIDE:  side_reg  <= cfg_data[0];
                CFG_UPPER: upper_reg <= cfg_data[0];
                CFG_TRANS: trans_reg <= cfg_data[0];
                CFG_UNIT:  unit_reg  <= cfg_data[0];
                CFG_ROWS:  rows_reg  <= cfg_data[DIM_W-1:0];
                CFG_COLS:  cols_reg  <= cfg_data[DIM_W-1:0];
                CFG_ALPHA: alpha_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stores: one write port each, registered read
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rd <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        b_rd <= b_mem[b_raddr];
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        sc_ret_next = sc_ret_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        bh_next     = bh_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        sat_next    = sat_reg;
        ov_next     = (ov_reg && m_tready) ? 1'b0 : ov_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        osat_next   = osat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_act == ACT_RUN)
                begin
                    sat_next = 1'b0;
                    m_next   = m_clamp;
                    n_next   = n_clamp;
                    i_next   = '0;
                    j_next   = '0;
                    if (m_clamp == '0 || n_clamp == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (alpha_reg == '0)
                    begin
                        state_next = S_CLR;
                    end
                    else if (!side_reg)
                    begin
                        if (!trans_reg)
                        begin
                            k_next     = upper_reg ? '0 : IDX_W'(m_clamp - DIM_W'(1));
                            state_next = S_L1_RD;
                        end
                        else
                        begin
                            i_next     = upper_reg ? IDX_W'(m_clamp - DIM_W'(1)) : '0;
                            state_next = S_L2_RD;
                        end
                    end
                    else
                    begin
                        j_next     = r_asc ? '0 : IDX_W'(n_clamp - DIM_W'(1));
                        state_next = S_R_OS;
                    end
                end
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    state_next = ret_reg;
                    if (mul_sat)
                    begin
                        sat_next = 1'b1;
                    end
                end
            end
            S_CLR:
            begin
                if (i_reg == mlast)
                begin
                    i_next = '0;
                    if (j_reg == nlast)
                    begin
                        j_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_ERD: state_next = S_ELD;
            S_ELD:
            begin
                ov_next    = 1'b1;
                orow_next  = i_reg;
                ocol_next  = j_reg;
                oval_next  = b_rd;
                olast_next = (i_reg == mlast) && (j_reg == nlast);
                osat_next  = sat_reg;
                state_next = S_EWT;
            end
            S_EWT:
            begin
                if (m_tready)
                begin
                    if (olast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ERD;
                        if (i_reg == mlast)
                        begin
                            i_next = '0;
                            j_next = j_reg + IDX_W'(1);
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                end
            end

            // left side, no transpose
            S_L1_RD: state_next = S_L1_CK;
            S_L1_CK:
            begin
                if (b_rd == '0)
                begin
                    state_next = S_L1_ADV;
                end
                else
                begin
                    ret_next   = S_L1_T;
                    state_next = S_MWAIT;
                end
            end
            S_L1_T:
            begin
                t_next = mul_res;
                if (!upper_reg)
                begin
                    i_next     = mlast;
                    state_next = (mlast > k_reg) ? S_L1_IRD : S_L1_DG;
                end
                else
                begin
                    i_next     = '0;
                    state_next = (k_reg != '0) ? S_L1_IRD : S_L1_DG;
                end
            end
            S_L1_IRD: state_next = S_L1_IM;
            S_L1_IM:
            begin
                bh_next    = b_rd;
                ret_next   = S_L1_IA;
                state_next = S_MWAIT;
            end
            S_L1_IA:
            begin
                if (add_out[WORD_W])
                begin
                    sat_next = 1'b1;
                end
                if (!upper_reg)
                begin
                    i_next     = i_reg - IDX_W'(1);
                    state_next = ((i_reg - IDX_W'(1)) > k_reg) ? S_L1_IRD : S_L1_DG;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ((i_reg + IDX_W'(1)) < k_reg) ? S_L1_IRD : S_L1_DG;
                end
            end
            S_L1_DG: state_next = nounit ? S_L1_DM : S_L1_WR;
            S_L1_DM:
            begin
                ret_next   = S_L1_DT;
                state_next = S_MWAIT;
            end
            S_L1_DT:
            begin
                t_next     = mul_res;
                state_next = S_L1_WR;
            end
            S_L1_WR: state_next = S_L1_ADV;
            S_L1_ADV:
            begin
                if ((!upper_reg && k_reg == '0) || (upper_reg && k_reg == mlast))
                begin
                    if (j_reg == nlast)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        k_next     = upper_reg ? '0 : mlast;
                        state_next = S_L1_RD;
                    end
                end
                else
                begin
                    k_next     = upper_reg ? (k_reg + IDX_W'(1)) : (k_reg - IDX_W'(1));
                    state_next = S_L1_RD;
                end
            end

            // left side, transpose
            S_L2_RD: state_next = S_L2_T0;
            S_L2_T0:
            begin
                t_next     = b_rd;
                state_next = nounit ? S_L2_DM : S_L2_KS;
            end
            S_L2_DM:
            begin
                ret_next   = S_L2_DT;
                state_next = S_MWAIT;
            end
            S_L2_DT:
            begin
                t_next     = mul_res;
                state_next = S_L2_KS;
            end
            S_L2_KS:
            begin
                if (!upper_reg)
                begin
                    k_next     = i_reg + IDX_W'(1);
                    state_next = (i_reg != mlast) ? S_L2_KRD : S_L2_FIN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = (i_reg != '0) ? S_L2_KRD : S_L2_FIN;
                end
            end
            S_L2_KRD: state_next = S_L2_KM;
            S_L2_KM:
            begin
                ret_next   = S_L2_KA;
                state_next = S_MWAIT;
            end
            S_L2_KA:
            begin
                t_next = add_out[WORD_W-1:0];
                if (add_out[WORD_W])
                begin
                    sat_next = 1'b1;
                end
                k_next = k_reg + IDX_W'(1);
                if ((!upper_reg && k_reg == mlast) ||
                    (upper_reg && (k_reg + IDX_W'(1)) == i_reg))
                begin
                    state_next = S_L2_FIN;
                end
                else
                begin
                    state_next = S_L2_KRD;
                end
            end
            S_L2_FIN:
            begin
                ret_next   = S_L2_WR;
                state_next = S_MWAIT;
            end
            S_L2_WR:
            begin
                if ((!upper_reg && i_reg == mlast) || (upper_reg && i_reg == '0))
                begin
                    if (j_reg == nlast)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        i_next     = upper_reg ? mlast : '0;
                        state_next = S_L2_RD;
                    end
                end
                else
                begin
                    i_next     = upper_reg ? (i_reg - IDX_W'(1)) : (i_reg + IDX_W'(1));
                    state_next = S_L2_RD;
                end
            end

            // right side: outer column j, inner column k
            S_R_OS:
            begin
                if (!trans_reg)
                begin
                    sc_ret_next = S_R_PS;
                    state_next  = S_SC;
                end
                else
                begin
                    state_next = S_R_PS;
                end
            end
            S_R_PS:
            begin
                if (!upper_reg)
                begin
                    k_next     = j_reg + IDX_W'(1);
                    state_next = (j_reg != nlast) ? S_AX : S_R_PE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = (j_reg != '0) ? S_AX : S_R_PE;
                end
            end
            S_R_PE:
            begin
                if (trans_reg)
                begin
                    sc_ret_next = S_R_OA;
                    state_next  = S_SC;
                end
                else
                begin
                    state_next = S_R_OA;
                end
            end
            S_R_OA:
            begin
                if ((r_asc && j_reg == nlast) || (!r_asc && j_reg == '0))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    j_next     = r_asc ? (j_reg + IDX_W'(1)) : (j_reg - IDX_W'(1));
                    state_next = S_R_OS;
                end
            end
            S_AX: state_next = S_AX_CK;
            S_AX_CK:
            begin
                if (a_rd == '0)
                begin
                    state_next = S_AX_NX;
                end
                else
                begin
                    ret_next   = S_AX_F;
                    state_next = S_MWAIT;
                end
            end
            S_AX_F:
            begin
                t_next     = mul_res;
                i_next     = '0;
                state_next = S_AX_RD1;
            end
            S_AX_RD1: state_next = S_AX_M;
            S_AX_M:
            begin
                ret_next   = S_AX_RD2;
                state_next = S_MWAIT;
            end
            S_AX_RD2: state_next = S_AX_A;
            S_AX_A:
            begin
                if (add_out[WORD_W])
                begin
                    sat_next = 1'b1;
                end
                if (i_reg == mlast)
                begin
                    state_next = S_AX_NX;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_AX_RD1;
                end
            end
            S_AX_NX:
            begin
                k_next = k_reg + IDX_W'(1);
                if ((!upper_reg && k_reg == nlast) ||
                    (upper_reg && (k_reg + IDX_W'(1)) == j_reg))
                begin
                    state_next = S_R_PE;
                end
                else
                begin
                    state_next = S_AX;
                end
            end

            // column scale by alpha, times the diagonal when non-unit
            S_SC:
            begin
                if (nounit)
                begin
                    state_next = S_SC_M;
                end
                else
                begin
                    t_next     = alpha_reg;
                    state_next = S_SC_CK;
                end
            end
            S_SC_M:
            begin
                ret_next   = S_SC_T;
                state_next = S_MWAIT;
            end
            S_SC_T:
            begin
                t_next     = mul_res;
                state_next = S_SC_CK;
            end
            S_SC_CK:
            begin
                i_next     = '0;
                state_next = (t_reg == ONE_Q) ? sc_ret_reg : S_SC_RD;
            end
            S_SC_RD: state_next = S_SC_M2;
            S_SC_M2:
            begin
                ret_next   = S_SC_W;
                state_next = S_MWAIT;
            end
            S_SC_W:
            begin
                if (i_reg == mlast)
                begin
                    state_next = sc_ret_reg;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SC_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        a_raddr = '0;
        b_raddr = '0;
        a_we    = 1'b0;
        a_waddr = {in_row, in_col};
        a_wdata = in_val;
        b_we    = 1'b0;
        b_waddr = {in_row, in_col};
        b_wdata = in_val;
        mul_go  = 1'b0;
        mul_x   = alpha_reg;
        mul_y   = b_rd;
        add_a   = b_rd;

        case (state_reg)
            S_L1_IA:  add_a = bh_reg;
            S_L2_KA:  add_a = t_reg;
            default:  add_a = b_rd;
        endcase
        add_out = qadd(add_a, mul_res);

        case (state_reg)
            S_IDLE:
            begin
                // loads outside the store cannot occur: indexes cover it exactly
                a_we = in_acc && (in_act == ACT_LOAD_A);
                b_we = in_acc && (in_act == ACT_LOAD_B);
            end
            S_CLR:
            begin
                b_we    = 1'b1;
                b_waddr = {i_reg, j_reg};
                b_wdata = '0;
            end
            S_ERD:    b_raddr = {i_reg, j_reg};
            S_L1_RD:  b_raddr = {k_reg, j_reg};
            S_L1_CK:
            begin
                mul_go = (b_rd != '0);
                mul_x  = alpha_reg;
                mul_y  = b_rd;
            end
            S_L1_IRD:
            begin
                b_raddr = {i_reg, j_reg};
                a_raddr = {i_reg, k_reg};
            end
            S_L1_IM:
            begin
                mul_go = 1'b1;
                mul_x  = t_reg;
                mul_y  = a_rd;
            end
            S_L1_IA:
            begin
                b_we    = 1'b1;
                b_waddr = {i_reg, j_reg};
                b_wdata = add_out[WORD_W-1:0];
            end
            S_L1_DG:  a_raddr = {k_reg, k_reg};
            S_L1_DM:
            begin
                mul_go = 1'b1;
                mul_x  = t_reg;
                mul_y  = a_rd;
            end
            S_L1_WR:
            begin
                b_we    = 1'b1;
                b_waddr = {k_reg, j_reg};
                b_wdata = t_reg;
            end
            S_L2_RD:  b_raddr = {i_reg, j_reg};
            S_L2_T0:  a_raddr = {i_reg, i_reg};
            S_L2_DM:
            begin
                mul_go = 1'b1;
                mul_x  = t_reg;
                mul_y  = a_rd;
            end
            S_L2_KRD:
            begin
                a_raddr = {k_reg, i_reg};
                b_raddr = {k_reg, j_reg};
            end
            S_L2_KM:
            begin
                mul_go = 1'b1;
                mul_x  = a_rd;
                mul_y  = b_rd;
            end
            S_L2_FIN:
            begin
                mul_go = 1'b1;
                mul_x  = alpha_reg;
                mul_y  = t_reg;
            end
            S_L2_WR:
            begin
                b_we    = 1'b1;
                b_waddr = {i_reg, j_reg};
                b_wdata = mul_res;
            end
            S_AX:     a_raddr = {k_reg, j_reg};
            S_AX_CK:
            begin
                mul_go = (a_rd != '0);
                mul_x  = alpha_reg;
                mul_y  = a_rd;
            end
            S_AX_RD1: b_raddr = {i_reg, ax_src};
            S_AX_M:
            begin
                mul_go = 1'b1;
                mul_x  = t_reg;
                mul_y  = b_rd;
            end
            S_AX_RD2: b_raddr = {i_reg, ax_dst};
            S_AX_A:
            begin
                b_we    = 1'b1;
                b_waddr = {i_reg, ax_dst};
                b_wdata = add_out[WORD_W-1:0];
            end
            S_SC:     a_raddr = {j_reg, j_reg};
            S_SC_M:
            begin
                mul_go = 1'b1;
                mul_x  = alpha_reg;
                mul_y  = a_rd;
            end
            S_SC_RD:  b_raddr = {i_reg, j_reg};
            S_SC_M2:
            begin
                mul_go = 1'b1;
                mul_x  = b_rd;
                mul_y  = t_reg;
            end
            S_SC_W:
            begin
                b_we    = 1'b1;
                b_waddr = {i_reg, j_reg};
                b_wdata = mul_res;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            sc_ret_reg <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            n_reg      <= '0;
            sat_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            sc_ret_reg <= sc_ret_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            m_reg      <= m_next;
            n_reg      <= n_next;
            sat_reg    <= sat_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        bh_reg    <= bh_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
        osat_reg  <= osat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oval_reg, ocol_reg, orow_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = osat_reg;

endmodule

@@ tb/triangular_matrix_multiply_core_tb.sv @@
// Self-checking testbench for the triangular matrix multiply core: stimulus, predictor, checks.
`timescale 1ns / 1ps

module triangular_matrix_multiply_core_tb;
    import tmm_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] value;
        logic        last;
        logic        sat;
    } b_elem_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // row_index[2:0], col_index[5:3], element_value[69:6]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // out_row[2:0], out_col[5:3], out_value[69:6]
    logic        m_tlast;
    logic        m_tuser;   // saturated[0]

    // predictor state
    logic [63:0] mdl_a [8][8];
    logic [63:0] mdl_b [8][8];
    logic        mdl_sat;
    logic        mdl_side, mdl_upper, mdl_trans, mdl_unit;
    logic [3:0]  mdl_rows, mdl_cols;
    logic [63:0] mdl_alpha;

    b_elem_t     expected_b [$];
    int          error_count;
    int          cycle_count;
    bit          idle_on;
    int          hold_req;
    int          hold_left;
    int          burst_left;

    triangular_matrix_multiply_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Fixed-point arithmetic of the predictor
    // ---------------------------------------------------------------

    // Q32.32 multiply, round half-up, saturate to 64 bits
    function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] mx, my, p, q;
        logic         neg;
        neg = x[63] ^ y[63];
        mx  = {64'd0, x[63] ? (64'd0 - x) : x};
        my  = {64'd0, y[63] ? (64'd0 - y) : y};
        p   = mx * my;
        if (neg)
        begin
            p = 128'd0 - p;
        end
        p = p + (128'd1 << (FRAC_BITS - 1));
        q = $signed(p) >>> FRAC_BITS;
        if (q[127:63] != {65{q[63]}})
        begin
            mdl_sat = 1'b1;
            return p[127] ? SIGN_MIN : SIGN_MAX;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] fx_add(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        r = x + y;
        if (x[63] == y[63] && r[63] != x[63])
        begin
            mdl_sat = 1'b1;
            return x[63] ? SIGN_MIN : SIGN_MAX;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Product update, one routine per side
    // ---------------------------------------------------------------

    function automatic void update_left(input int m, input int n, input logic [63:0] al,
                                        input bit nonunit);
        logic [63:0] t;
        for (int j = 0; j < n; j++)
        begin
            if (!mdl_trans && !mdl_upper)
            begin
                for (int k = m - 1; k >= 0; k--)
                begin
                    if (mdl_b[k][j] != 64'd0)
                    begin
                        t = fx_mul(al, mdl_b[k][j]);
                        for (int i = m - 1; i > k; i--)
                            mdl_b[i][j] = fx_add(mdl_b[i][j], fx_mul(t, mdl_a[i][k]));
                        if (nonunit) t = fx_mul(t, mdl_a[k][k]);
                        mdl_b[k][j] = t;
                    end
                end
            end
            else if (!mdl_trans)
            begin
                for (int k = 0; k < m; k++)
                begin
                    if (mdl_b[k][j] != 64'd0)
                    begin
                        t = fx_mul(al, mdl_b[k][j]);
                        for (int i = 0; i < k; i++)
                            mdl_b[i][j] = fx_add(mdl_b[i][j], fx_mul(t, mdl_a[i][k]));
                        if (nonunit) t = fx_mul(t, mdl_a[k][k]);
                        mdl_b[k][j] = t;
                    end
                end
            end
            else if (!mdl_upper)
            begin
                for (int i = 0; i < m; i++)
                begin
                    t = mdl_b[i][j];
                    if (nonunit) t = fx_mul(t, mdl_a[i][i]);
                    for (int k = i + 1; k < m; k++)
                        t = fx_add(t, fx_mul(mdl_a[k][i], mdl_b[k][j]));
                    mdl_b[i][j] = fx_mul(al, t);
                end
            end
            else
            begin
                for (int i = m - 1; i >= 0; i--)
                begin
                    t = mdl_b[i][j];
                    if (nonunit) t = fx_mul(t, mdl_a[i][i]);
                    for (int k = 0; k < i; k++)
                        t = fx_add(t, fx_mul(mdl_a[k][i], mdl_b[k][j]));
                    mdl_b[i][j] = fx_mul(al, t);
                end
            end
        end
    endfunction

    // column scale, skipped when the factor is exactly one
    function automatic void scale_column(input int m, input int c, input logic [63:0] al,
                                         input bit nonunit);
        logic [63:0] t;
        t = al;
        if (nonunit) t = fx_mul(t, mdl_a[c][c]);
        if (t != ONE_Q)
            for (int i = 0; i < m; i++) mdl_b[i][c] = fx_mul(mdl_b[i][c], t);
    endfunction

    // dst column += alpha*aval*src column, skipped on a zero element
    function automatic void add_column(input int m, input int dst, input int src,
                                       input logic [63:0] aval, input logic [63:0] al);
        logic [63:0] f;
        if (aval != 64'd0)
        begin
            f = fx_mul(al, aval);
            for (int i = 0; i < m; i++)
                mdl_b[i][dst] = fx_add(mdl_b[i][dst], fx_mul(f, mdl_b[i][src]));
        end
    endfunction

    function automatic void update_right(input int m, input int n, input logic [63:0] al,
                                         input bit nonunit);
        if (!mdl_trans && !mdl_upper)
        begin
            for (int j = 0; j < n; j++)
            begin
                scale_column(m, j, al, nonunit);
                for (int k = j + 1; k < n; k++) add_column(m, j, k, mdl_a[k][j], al);
            end
        end
        else if (!mdl_trans)
        begin
            for (int j = n - 1; j >= 0; j--)
            begin
                scale_column(m, j, al, nonunit);
                for (int k = 0; k < j; k++) add_column(m, j, k, mdl_a[k][j], al);
            end
        end
        else if (!mdl_upper)
        begin
            for (int k = n - 1; k >= 0; k--)
            begin
                for (int j = k + 1; j < n; j++) add_column(m, j, k, mdl_a[j][k], al);
                scale_column(m, k, al, nonunit);
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                for (int j = 0; j < k; j++) add_column(m, j, k, mdl_a[j][k], al);
                scale_column(m, k, al, nonunit);
            end
        end
    endfunction

    // Applies one accepted item to the predictor and queues the B elements it emits.
    function automatic void apply_item(input action_t act, input logic [2:0] row,
                                       input logic [2:0] col, input logic [63:0] val);
        int      m, n;
        b_elem_t e;
        case (act)
            ACT_LOAD_A: mdl_a[row][col] = val;
            ACT_LOAD_B: mdl_b[row][col] = val;
            ACT_RUN:
            begin
                mdl_sat = 1'b0;
                // oversize dimensions clamp to the store size
                m = (mdl_rows > 4'd8) ? 8 : int'(mdl_rows);
                n = (mdl_cols > 4'd8) ? 8 : int'(mdl_cols);
                if (m != 0 && n != 0)
                begin
                    if (mdl_alpha == 64'd0)
                    begin
                        for (int j = 0; j < n; j++)
                            for (int i = 0; i < m; i++) mdl_b[i][j] = 64'd0;
                    end
                    else if (!mdl_side)
                        update_left(m, n, mdl_alpha, !mdl_unit);
                    else
                        update_right(m, n, mdl_alpha, !mdl_unit);
                    for (int j = 0; j < n; j++)
                        for (int i = 0; i < m; i++)
                        begin
                            e.row   = 3'(i);
                            e.col   = 3'(j);
                            e.value = mdl_b[i][j];
                            e.last  = (i == m - 1 && j == n - 1);
                            e.sat   = mdl_sat;
                            expected_b.push_back(e);
                        end
                end
            end
            default: ; // unknown action: ignored
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready with random stalls and a long hold on request
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  = 0;
            burst_left = 0;
        end
        else
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        b_elem_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_b.size() == 0)
                report_mismatch($sformatf("unexpected B element row %0d col %0d",
                                          m_tdata[2:0], m_tdata[5:3]));
            else
            begin
                e = expected_b.pop_front();
                if (m_tdata[2:0] !== e.row || m_tdata[5:3] !== e.col ||
                    m_tdata[69:6] !== e.value || m_tlast !== e.last || m_tuser !== e.sat)
                    report_mismatch($sformatf(
                        "got r%0d c%0d v%h l%b s%b, want r%0d c%0d v%h l%b s%b",
                        m_tdata[2:0], m_tdata[5:3], m_tdata[69:6], m_tlast, m_tuser,
                        e.row, e.col, e.value, e.last, e.sat));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triangular_matrix_multiply_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly values within +-4.0, some full-range words, the extremes, zero and one.
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return v;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return SIGN_MIN;
                    1: return SIGN_MAX;
                    2: return 64'd0;
                    default: return ONE_Q;
                endcase
            end
            default: return $signed(v) >>> 29;
        endcase
    endfunction

    function automatic logic [63:0] rand_alpha();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return ONE_Q;
            1: return 64'd0;
            default: return $signed(v) >>> 30;
        endcase
    endfunction

    // Offers one item and waits until it is taken.
    task automatic send_item(input action_t act, input logic [2:0] row,
                             input logic [2:0] col, input logic [63:0] val);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, val, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        apply_item(act, row, col, val);
    endtask

    // Drops valid, waits for all B elements, then lets the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_b.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SIDE:  mdl_side  = val[0];
            CFG_UPPER: mdl_upper = val[0];
            CFG_TRANS: mdl_trans = val[0];
            CFG_UNIT:  mdl_unit  = val[0];
            CFG_ROWS:  mdl_rows  = val[3:0];
            CFG_COLS:  mdl_cols  = val[3:0];
            CFG_ALPHA: mdl_alpha = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input bit side, input bit upper, input bit trans, input bit unit_d,
                            input logic [3:0] rows, input logic [3:0] cols,
                            input logic [63:0] alpha);
        wait_drained();
        write_reg(CFG_SIDE, {63'd0, side});
        write_reg(CFG_UPPER, {63'd0, upper});
        write_reg(CFG_TRANS, {63'd0, trans});
        write_reg(CFG_UNIT, {63'd0, unit_d});
        write_reg(CFG_ROWS, {60'd0, rows});
        write_reg(CFG_COLS, {60'd0, cols});
        write_reg(CFG_ALPHA, alpha);
    endtask

    function automatic logic [3:0] rand_dim();
        return ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom_range(1, 5));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every store entry gets written before any run reads it.
    task automatic test_fill_stores();
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
            begin
                send_item(ACT_LOAD_A, 3'(r), 3'(c), rand_value());
                send_item(ACT_LOAD_B, 3'(r), 3'(c), rand_value());
            end
    endtask

    // Reset defaults, extremes of the value field, unknown action.
    task automatic test_defaults_and_extremes();
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        send_item(ACT_LOAD_B, 3'd7, 3'd7, SIGN_MAX);
        send_item(ACT_LOAD_B, 3'd0, 3'd0, SIGN_MIN);
        send_item(ACT_LOAD_A, 3'd7, 3'd7, SIGN_MIN);
        send_item(ACT_LOAD_A, 3'd0, 3'd0, SIGN_MAX);
        send_item(ACT_LOAD_B, 3'd3, 3'd4, 64'd0);
        send_item(ACT_NONE, 3'd7, 3'd7, {64{1'b1}});
        send_item(ACT_RUN, 3'd7, 3'd7, {64{1'b1}});
    endtask

    // All eight loop orders, unit and non-unit diagonal.
    task automatic test_all_cases();
        for (int c = 0; c < 8; c++)
        begin
            set_mode(c[2], c[1], c[0], c[0] ^ c[2], 4'($urandom_range(2, 8)),
                     4'($urandom_range(2, 8)), rand_alpha());
            send_item(ACT_LOAD_A, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      rand_value());
            send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        end
    endtask

    // Alpha zero and extremes, empty size, oversize dimensions.
    task automatic test_special_settings();
        set_mode(1'b0, 1'b1, 1'b0, 1'b0, 4'd3, 4'd2, 64'd0);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        set_mode(1'b1, 1'b0, 1'b1, 1'b1, 4'd2, 4'd3, SIGN_MIN);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        set_mode(1'b0, 1'b0, 1'b0, 1'b0, 4'd1, 4'd1, SIGN_MAX);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        set_mode(1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd4, ONE_Q);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        set_mode(1'b1, 1'b1, 1'b1, 1'b1, 4'd5, 4'd0, ONE_Q);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        set_mode(1'b1, 1'b1, 1'b0, 1'b0, 4'd15, 4'd9, 64'hFFFF_FFFF_8000_0000);
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    // The hold outlasts the 4x4 compute phase, so results back up.
    task automatic test_output_hold();
        set_mode(1'b0, 1'b0, 1'b1, 1'b0, 4'd4, 4'd4, ONE_Q);
        hold_req = 2000;
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        for (int i = 0; i < 4; i++)
            send_item(ACT_LOAD_B, 3'(i), 3'(i), rand_value());
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
        // sender pause: nothing offered until every element is back
        wait_drained();
        send_item(ACT_RUN, 3'd0, 3'd0, 64'd0);
    endtask

    // Random configuration, then loads with random content, occasional runs and unknown actions.
    task automatic test_random_phases(input int phases);
        int pick;
        for (int p = 0; p < phases; p++)
        begin
            set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     rand_dim(), rand_dim(), rand_alpha());
            for (int i = 0; i < 14; i++)
            begin
                pick = $urandom_range(0, 15);
                if (pick < 7)
                    send_item(ACT_LOAD_A, 3'($urandom), 3'($urandom), rand_value());
                else if (pick < 13)
                    send_item(ACT_LOAD_B, 3'($urandom), 3'($urandom), rand_value());
                else if (pick < 15 || i == 13)
                    send_item(ACT_RUN, 3'($urandom), 3'($urandom), rand_value());
                else
                    send_item(ACT_NONE, 3'($urandom), 3'($urandom), rand_value());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_SIDE;
        cfg_data    <= 64'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 72'd0;
        s_tuser     <= ACT_LOAD_A;
        error_count = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_req    = 0;
        mdl_sat     = 1'b0;
        mdl_side    = 1'b0;
        mdl_upper   = 1'b0;
        mdl_trans   = 1'b0;
        mdl_unit    = 1'b0;
        mdl_rows    = 4'd8;
        mdl_cols    = 4'd8;
        mdl_alpha   = ONE_Q;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_stores();
        test_defaults_and_extremes();
        test_all_cases();
        test_special_settings();
        test_output_hold();
        test_random_phases(4);
        // closing stretch runs with no idling on either side
        idle_on = 1'b0;
        test_random_phases(2);
        wait_drained();

        if (error_count == 0)
            $display("triangular_matrix_multiply_core verification clean");
        else
            $display("triangular_matrix_multiply_core verification failed");
        $finish;
    end

endmodule

@@ triangular_matrix_multiply_core.f @@
sv/tmm_pkg.sv
sv/tmm_mul_cell.sv
sv/tmm_qmul.sv
sv/triangular_matrix_multiply_core.sv
tb/triangular_matrix_multiply_core_tb.sv
